[hdl/rwib_pkg.sv]
// Shared types and constants for the write-intent bitmap block.
// No dependencies.
package rwib_pkg;
  localparam int PageBytes    = 4096;
  localparam int NumPages     = 8;
  localparam int WordsPerPage = PageBytes / 8;
  localparam int StoreWords   = NumPages * WordsPerPage;
  localparam int AddrW        = 48;
  localparam int LenW         = 25;
  localparam int ChunkW       = 25;
  localparam int PageW        = 3;
  localparam int WordIdxW     = $clog2(StoreWords);
  localparam int PwordW       = $clog2(WordsPerPage);
  localparam int BitOffW      = $clog2(PageBytes * 8);
  localparam int PwW          = ChunkW + BitOffW;
  localparam logic [0:0] ActMark  = 1'b0;
  localparam logic [0:0] ActQuery = 1'b1;

  // Job handed from the front part to the back part through the queue.
  typedef struct packed {
    logic                action;
    logic                walk;
    logic [PageW-1:0]    page;
    logic [PwordW-1:0]   first_word;
    logic [PwordW-1:0]   last_word;
    logic [5:0]          first_bit;
    logic [5:0]          last_bit;
    logic [LenW-1:0]     size;
    logic                oor;
  } job_t;
endpackage

[hdl/rwib_front.sv]
// Front part: divides the address by the page width and chunk size serially,
// then builds a word-walk job. Depends on rwib_pkg.
module rwib_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [rwib_pkg::AddrW-1:0]    byte_address,
  input  logic [rwib_pkg::LenW-1:0]     byte_length,
  input  logic [rwib_pkg::ChunkW-1:0]   chunk_bytes,
  output logic                          job_valid,
  output rwib_pkg::job_t                job,
  input  logic                          job_ready
);
  import rwib_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIVA, S_SETUP, S_DIVB, S_DIVC, S_PUSH} state_t;

  state_t            state;
  logic [5:0]        cnt;
  logic              act;
  logic [LenW-1:0]   len;
  logic [ChunkW-1:0] chunk;
  logic [PwW-1:0]    pw;
  logic [AddrW-1:0]  quot;
  logic [PwW:0]      rem;
  logic [PwW-1:0]    last_off;
  logic [LenW-1:0]   size;
  logic [AddrW-1:0]  page_q;
  logic [BitOffW-1:0] first_c;
  logic [PwW-1:0]    room;
  logic [PwW:0]      rem_sh;
  logic [PwW:0]      rem_sub;
  logic [PwW:0]      div_d;

  assign busy = (state != S_IDLE);
  // used in S_SETUP, where rem holds the offset within the page
  assign room = pw - rem[PwW-1:0];
  assign div_d = (state == S_DIVA) ? {1'b0, pw} : {{(PwW + 1 - ChunkW){1'b0}}, chunk};
  assign rem_sh = {rem[PwW-1:0], quot[AddrW-1]};
  assign rem_sub = rem_sh - div_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act   <= action;
            len   <= byte_length;
            chunk <= (chunk_bytes == '0) ? ChunkW'(1) : chunk_bytes;
            pw    <= PwW'((chunk_bytes == '0) ? ChunkW'(1) : chunk_bytes) << BitOffW;
            quot  <= byte_address;
            rem   <= '0;
            cnt   <= 6'(AddrW - 1);
            state <= S_DIVA;
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIVA, S_DIVB, S_DIVC: begin
          if (state == S_DIVB && cnt == '0) begin
            // hold the first chunk index, start on the last one
            cnt     <= 6'(AddrW - 1);
            quot    <= {{(AddrW - PwW){1'b0}}, last_off};
            rem     <= '0;
            first_c <= (!rem_sub[PwW]) ? BitOffW'({quot[AddrW-2:0], 1'b1})
                                       : BitOffW'({quot[AddrW-2:0], 1'b0});
            state   <= S_DIVC;
          end else begin
            if (!rem_sub[PwW]) begin
              rem  <= rem_sub;
              quot <= {quot[AddrW-2:0], 1'b1};
            end else begin
              rem  <= rem_sh;
              quot <= {quot[AddrW-2:0], 1'b0};
            end
            if (cnt == '0) state <= (state == S_DIVA) ? S_SETUP : S_PUSH;
            else cnt <= cnt - 6'd1;
          end
        end
        S_SETUP: begin
          page_q   <= quot;
          size     <= (PwW'(len) < room) ? len : LenW'(room);
          last_off <= rem[PwW-1:0] + PwW'((PwW'(len) < room) ? len : LenW'(room)) - PwW'(1);
          quot     <= {{(AddrW - PwW){1'b0}}, rem[PwW-1:0]};
          rem      <= '0;
          cnt      <= 6'(AddrW - 1);
          state    <= S_DIVB;
        end
        S_PUSH: begin
          if (!job_valid) begin
            job.action     <= act;
            job.page       <= page_q[PageW-1:0];
            job.size       <= size;
            job.oor        <= (page_q >= AddrW'(NumPages));
            job.walk       <= (page_q < AddrW'(NumPages)) && (size != '0);
            job.first_word <= first_c[BitOffW-1:6];
            job.first_bit  <= first_c[5:0];
            job.last_word  <= quot[BitOffW-1:6];
            job.last_bit   <= quot[5:0];
            job_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (job_valid && job_ready) job_valid <= 1'b0;
    end
  end
endmodule

[hdl/rwib_back.sv]
// Back part: walks the bitmap words of one job, marking or testing them,
// and issues the result strobe. Depends on rwib_pkg.
module rwib_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  rwib_pkg::job_t              job,
  output logic                        job_ready,
  output logic                        done,
  output logic [rwib_pkg::PageW-1:0]  page_index,
  output logic [rwib_pkg::LenW-1:0]   bytes_in_page,
  output logic                        newly_dirtied,
  output logic                        range_dirty,
  output logic                        out_of_range
);
  import rwib_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_CLEAR, B_READ, B_WAIT, B_APPLY, B_DONE} state_t;

  state_t              state;
  logic [63:0]         mem [StoreWords];
  logic [63:0]         rdata;
  job_t                cur;
  logic [PwordW-1:0]   w;
  logic [WordIdxW-1:0] clr;
  logic                newly;
  logic                dirty;
  logic [63:0]         mask;
  logic [63:0]         upper;
  logic [63:0]         lower;
  logic [5:0]          lo;
  logic [5:0]          hi;
  logic [WordIdxW-1:0] addr;
  logic                last;

  assign job_ready = (state == B_IDLE);
  assign lo = (w == cur.first_word) ? cur.first_bit : 6'd0;
  assign hi = (w == cur.last_word) ? cur.last_bit : 6'd63;
  assign upper = '1 >> (6'd63 - hi);
  assign lower = (64'd1 << lo) - 64'd1;
  assign mask = upper & ~lower;
  assign addr = {cur.page, w};
  assign last = (w == cur.last_word);

  always_ff @(posedge clk) begin
    if (state == B_CLEAR) mem[clr] <= '0;
    else if (state == B_APPLY && cur.action == ActMark) mem[addr] <= rdata | mask;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == B_DONE);
      unique case (state)
        // clear the whole store once after reset
        B_CLEAR: begin
          clr <= clr + WordIdxW'(1);
          if (clr == WordIdxW'(StoreWords - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            w     <= job.first_word;
            newly <= 1'b0;
            dirty <= 1'b0;
            state <= job.walk ? B_READ : B_DONE;
          end
        end
        B_READ: state <= B_WAIT;
        B_WAIT: state <= B_APPLY;
        B_APPLY: begin
          if (cur.action == ActMark) begin
            if ((rdata & mask) != mask) newly <= 1'b1;
          end else if ((rdata & mask) != '0) begin
            dirty <= 1'b1;
          end
          if (last) state <= B_DONE;
          else begin
            w     <= w + PwordW'(1);
            state <= B_READ;
          end
        end
        B_DONE: begin
          page_index    <= cur.page;
          bytes_in_page <= cur.size;
          newly_dirtied <= newly;
          range_dirty   <= dirty;
          out_of_range  <= cur.oor;
          state         <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

[hdl/raid_write_intent_bitmap_unit.sv]
// Write-intent bitmap unit: top level joining front, queue and back.
// Depends on rwib_pkg, rwib_front, rwib_back.
//
// Usage: drive action, byte_address and byte_length with start high; the
// request is taken at a clock edge where busy is low. One result follows per
// request, shown for one cycle with done high; the receiver cannot stall it.
// chunk_bytes must be written with chunk_wr only while the block is idle;
// the block itself does not enforce this. The front divides serially,
// one quotient bit per cycle: three 48-step divisions plus setup and
// hand-off keep busy high through each request, longer while the queue is
// full. The back walks bitmap words through one memory port, each word
// passing B_READ, B_WAIT and B_APPLY, up to 512 words per page, so long
// walks set the pace. A one-entry queue between them lets the front take the
// next request while the back still walks. Results come out in request
// order. Reset sets the chunk size to 32768 and sweeps the 4096-word bitmap
// to zero, one word per cycle; requests taken meanwhile wait in the queue.
module raid_write_intent_bitmap_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [rwib_pkg::AddrW-1:0]    byte_address,
  input  logic [rwib_pkg::LenW-1:0]     byte_length,
  input  logic                          chunk_wr,
  input  logic [rwib_pkg::ChunkW-1:0]   chunk_bytes,
  output logic                          done,
  output logic [rwib_pkg::PageW-1:0]    page_index,
  output logic [rwib_pkg::LenW-1:0]     bytes_in_page,
  output logic                          newly_dirtied,
  output logic                          range_dirty,
  output logic                          out_of_range
);
  import rwib_pkg::*;

  logic [ChunkW-1:0] chunk;
  logic              job_valid;
  logic              job_ready;
  job_t              job;

  always_ff @(posedge clk) begin
    if (rst) chunk <= ChunkW'(32768);
    else if (chunk_wr) chunk <= chunk_bytes;
  end

  rwib_front u_front (
    .clk, .rst, .start, .busy, .action, .byte_address, .byte_length,
    .chunk_bytes(chunk), .job_valid, .job, .job_ready
  );

  rwib_back u_back (
    .clk, .rst, .job_valid, .job, .job_ready, .done, .page_index,
    .bytes_in_page, .newly_dirtied, .range_dirty, .out_of_range
  );
endmodule

[hdl/rwib_checker.sv]
// Port-level checks for the write-intent bitmap unit, bound to the top level.
// Depends on rwib_pkg.
module rwib_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic                      newly_dirtied,
  input logic                      range_dirty,
  input logic                      out_of_range,
  input logic [rwib_pkg::LenW-1:0] bytes_in_page
);
  import rwib_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(newly_dirtied && range_dirty)) else $error("both flags set");
  a_oor_quiet: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> !newly_dirtied && !range_dirty)
    else $error("flag set on out-of-range page");
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    done && bytes_in_page == '0 |-> !newly_dirtied && !range_dirty)
    else $error("flag set on empty range");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back results");
endmodule

bind raid_write_intent_bitmap_unit rwib_checker u_checker (
  .clk, .rst, .start, .busy, .done, .newly_dirtied, .range_dirty,
  .out_of_range, .bytes_in_page
);

[sim/testbench.sv]
// Self-checking bench for the write-intent bitmap unit: directed table, then random phases.
// Uses rwib_pkg for widths and action codes, and an in-bench bitmap predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rwib_pkg::*;

  typedef struct {
    logic [PageW-1:0] page;
    logic [LenW-1:0]  size;
    logic             newly;
    logic             dirty;
    logic             oor;
  } bitmap_result_t;

  typedef struct {
    logic             act;
    longint unsigned  addr;
    longint unsigned  len;
    bit               typed;
    bitmap_result_t   res;
  } stim_row_t;

  localparam longint unsigned LenMax  = 64'd16777216;
  localparam longint unsigned AddrMax = (64'd1 << AddrW) - 1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               action = ActMark;
  logic [AddrW-1:0]   byte_address = '0;
  logic [LenW-1:0]    byte_length = '0;
  logic               chunk_wr = 1'b0;
  logic [ChunkW-1:0]  chunk_bytes = '0;
  logic               done;
  logic [PageW-1:0]   page_index;
  logic [LenW-1:0]    bytes_in_page;
  logic               newly_dirtied;
  logic               range_dirty;
  logic               out_of_range;

  logic [63:0]        bitmap_model [StoreWords];
  longint unsigned    chunk_model;
  bitmap_result_t     pending_results [$];
  int                 n_errors = 0;
  int                 n_checked = 0;
  int                 n_sent = 0;
  int                 idle_pct = 0;

  raid_write_intent_bitmap_unit i_dut (
    .clk, .rst, .start, .busy, .action, .byte_address, .byte_length,
    .chunk_wr, .chunk_bytes, .done, .page_index, .bytes_in_page,
    .newly_dirtied, .range_dirty, .out_of_range
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] span_bits(int lo, int hi);
    logic [63:0] upper, lower;
    upper = (hi == 63) ? '1 : ((64'd1 << (hi + 1)) - 1);
    lower = (64'd1 << lo) - 1;
    return upper & ~lower;
  endfunction

  // Update the bitmap copy and compute the result of one request.
  function automatic bitmap_result_t apply_bitmap_request(logic act, longint unsigned addr,
                                                           longint unsigned len);
    bitmap_result_t r;
    longint unsigned ce, pw, pg, off, room, sz, first, last, w, base;
    logic [63:0] m;
    int idx, lo, hi;
    ce = (chunk_model == 0) ? 1 : chunk_model;
    pw = ce * PageBytes * 8;
    pg = addr / pw;
    off = addr % pw;
    room = pw - off;
    sz = (len < room) ? len : room;
    r.page = pg[PageW-1:0];
    r.size = sz[LenW-1:0];
    r.newly = 1'b0;
    r.dirty = 1'b0;
    r.oor = 1'b0;
    if (pg >= NumPages) begin
      r.oor = 1'b1;
    end else if (sz > 0) begin
      first = off / ce;
      last = (off + sz - 1) / ce;
      base = pg * WordsPerPage;
      for (w = first / 64; w <= last / 64; w++) begin
        lo = (w == first / 64) ? int'(first % 64) : 0;
        hi = (w == last / 64) ? int'(last % 64) : 63;
        m = span_bits(lo, hi);
        idx = int'((base + w) % StoreWords);
        if (act == ActMark) begin
          if ((bitmap_model[idx] & m) != m) r.newly = 1'b1;
          bitmap_model[idx] |= m;
        end else if ((bitmap_model[idx] & m) != 0) begin
          r.dirty = 1'b1;
          break;
        end
      end
    end
    return r;
  endfunction

  // Drive one word and hold it until the block takes it.
  task automatic send_word(logic act, longint unsigned addr, longint unsigned len,
                           bit typed, bitmap_result_t want);
    bitmap_result_t r;
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    action = act;
    byte_address = addr[AddrW-1:0];
    byte_length = len[LenW-1:0];
    do @(posedge clk); while (busy);
    r = apply_bitmap_request(act, addr, len);
    pending_results.push_back(typed ? want : r);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_chunk(longint unsigned value);
    @(negedge clk);
    chunk_wr = 1'b1;
    chunk_bytes = value[ChunkW-1:0];
    chunk_model = value & ((64'd1 << ChunkW) - 1);
    @(negedge clk);
    chunk_wr = 1'b0;
  endtask

  always @(posedge clk) begin
    bitmap_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, page %0d size %0d", $realtime,
                 page_index, bytes_in_page);
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (page_index !== e.page || bytes_in_page !== e.size || newly_dirtied !== e.newly ||
            range_dirty !== e.dirty || out_of_range !== e.oor) begin
          n_errors++;
          $display("%0t: expected page %0d size %0d new %0b dirty %0b oor %0b,",
                   $realtime, e.page, e.size, e.newly, e.dirty, e.oor,
                   " got %0d %0d %0b %0b %0b", page_index,
                   bytes_in_page, newly_dirtied, range_dirty, out_of_range);
        end
      end
    end
  end

  function automatic bitmap_result_t res(int pg, longint unsigned sz, bit nw, bit dt, bit oor);
    bitmap_result_t r;
    r.page = pg[PageW-1:0];
    r.size = sz[LenW-1:0];
    r.newly = nw;
    r.dirty = dt;
    r.oor = oor;
    return r;
  endfunction

  initial begin
    stim_row_t rows [$];
    bitmap_result_t none;
    longint unsigned chunk_set [6];
    int idle_set [6];
    longint unsigned ce, pw, addr, len;
    int pick;
    logic act;

    none = res(0, 0, 0, 0, 0);
    chunk_model = 32768;
    foreach (bitmap_model[k]) bitmap_model[k] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default chunk 32768: one page spans 2^30 bytes.
    rows.push_back('{ActQuery, 0, 0, 1, res(0, 0, 0, 0, 0)});
    rows.push_back('{ActQuery, 0, 1, 1, res(0, 1, 0, 0, 0)});
    rows.push_back('{ActMark, 0, 0, 1, res(0, 0, 0, 0, 0)});
    rows.push_back('{ActMark, 0, 1, 1, res(0, 1, 1, 0, 0)});
    rows.push_back('{ActMark, 0, 1, 1, res(0, 1, 0, 0, 0)});
    rows.push_back('{ActQuery, 0, 1, 1, res(0, 1, 0, 1, 0)});
    rows.push_back('{ActMark, AddrMax, LenMax, 1, res(7, 1, 0, 0, 1)});
    rows.push_back('{ActQuery, AddrMax, 0, 1, res(7, 0, 0, 0, 1)});
    rows.push_back('{ActMark, 64'd8 << 30, 5, 1, res(0, 5, 0, 0, 1)});
    rows.push_back('{ActMark, (64'd8 << 30) - 1, LenMax, 1, res(7, 1, 1, 0, 0)});
    rows.push_back('{ActQuery, (64'd7 << 30), LenMax, 0, none});
    rows.push_back('{ActMark, 32767, 2, 0, none});
    rows.push_back('{ActQuery, 32768, 1, 0, none});
    rows.push_back('{ActMark, (64'd5 << 30) + 100, LenMax, 0, none});
    rows.push_back('{ActQuery, (64'd5 << 30) + 64'd16777000, 1000, 0, none});
    rows.push_back('{ActMark, (64'd5 << 30) + 50, 10, 0, none});
    rows.push_back('{ActQuery, (64'd3 << 30), LenMax, 0, none});
    rows.push_back('{ActMark, (64'd1 << 30) - 20, 100, 0, none});
    foreach (rows[i]) send_word(rows[i].act, rows[i].addr, rows[i].len, rows[i].typed,
                                rows[i].res);
    drain();

    chunk_set = '{32768, 1, LenMax, 0, 4096, 0};
    chunk_set[5] = 64'($urandom_range(2, 16777215));
    idle_set = '{0, 57, 0, 6, 57, 6};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_chunk(chunk_set[ph]);
      idle_pct = idle_set[ph];
      ce = (chunk_model == 0) ? 1 : chunk_model;
      pw = ce * PageBytes * 8;
      for (int n = 0; n < 275; n++) begin
        act = 1'($urandom_range(1));
        pick = int'($urandom_range(99));
        // Keep half of the words in a hot zone so queries see marked chunks.
        if (pick < 50)
          addr = $urandom_range(0, 7) * pw + ({$urandom, $urandom} % (64 * ce));
        else if (pick < 75)
          addr = $urandom_range(0, 7) * pw + ({$urandom, $urandom} % pw);
        else if (pick < 88)
          addr = ($urandom_range(1, 8) * pw - $urandom_range(1, 300)) & AddrMax;
        else
          addr = {$urandom, $urandom} & AddrMax;
        pick = int'($urandom_range(99));
        if (pick < 65) begin
          len = {$urandom, $urandom} % (4 * ce + 1);
          if (len > LenMax) len = LenMax;
        end else if (pick < 85)
          len = 64'($urandom_range(0, 16777216));
        else if (pick < 93)
          len = LenMax;
        else
          len = 64'($urandom_range(0, 3));
        send_word(act, addr, len, 0, none);
      end
      drain();
    end

    $display("Sent %0d requests over six chunk sizes (1, 0, 4096, 32768, 2^24, random);",
             n_sent);
    $display("checked %0d results, %0d failures.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("raid_write_intent_bitmap_unit: match");
    end else begin
      $display("raid_write_intent_bitmap_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #(64'd400_000_000);
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("raid_write_intent_bitmap_unit: mismatch");
    $finish;
  end
endmodule

[files.f]
hdl/rwib_pkg.sv
hdl/rwib_front.sv
hdl/rwib_back.sv
hdl/raid_write_intent_bitmap_unit.sv
hdl/rwib_checker.sv
sim/testbench.sv
